/* rtl/core/cigar_string_parser_assert.svh */
// assertion macros used by the cigar string parser checker
`ifndef CIGAR_STRING_PARSER_ASSERT_SVH
`define CIGAR_STRING_PARSER_ASSERT_SVH

// checked on every clock edge outside reset
`define CSP_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// checked on every clock edge, reset included
`define CSP_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

/* rtl/core/csp_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// csp_pkg
// Operation codes, character constants and the letter lookup used by the
// cigar string parser and its checker.
// ---------------------------------------------------------------------------
package csp_pkg;

   localparam int unsigned OUT_LEN_BITS = 32;

   typedef enum logic [3:0] {
      OP_M       = 4'd0,
      OP_EQ      = 4'd1,
      OP_X       = 4'd2,
      OP_I       = 4'd3,
      OP_D       = 4'd4,
      OP_S       = 4'd5,
      OP_N       = 4'd6,
      OP_H       = 4'd7,
      OP_P       = 4'd8,
      OP_UNKNOWN = 4'd9,
      OP_END     = 4'd10
   } op_code_type;

   localparam logic [7:0] CHAR_NUL  = 8'h00;
   localparam logic [7:0] CHAR_ZERO = 8'h30;
   localparam logic [7:0] CHAR_NINE = 8'h39;
   localparam logic [7:0] CHAR_M    = 8'h4D;
   localparam logic [7:0] CHAR_EQ   = 8'h3D;
   localparam logic [7:0] CHAR_X    = 8'h58;
   localparam logic [7:0] CHAR_I    = 8'h49;
   localparam logic [7:0] CHAR_D    = 8'h44;
   localparam logic [7:0] CHAR_S    = 8'h53;
   localparam logic [7:0] CHAR_N    = 8'h4E;
   localparam logic [7:0] CHAR_H    = 8'h48;
   localparam logic [7:0] CHAR_P    = 8'h50;

   localparam logic [3:0] DECIMAL_BASE = 4'd10;

   function automatic op_code_type op_lookup(input logic [7:0] ch);
      op_code_type code;
      unique case (ch)
         CHAR_M:  code = OP_M;
         CHAR_EQ: code = OP_EQ;
         CHAR_X:  code = OP_X;
         CHAR_I:  code = OP_I;
         CHAR_D:  code = OP_D;
         CHAR_S:  code = OP_S;
         CHAR_N:  code = OP_N;
         CHAR_H:  code = OP_H;
         CHAR_P:  code = OP_P;
         default: code = OP_UNKNOWN;
      endcase
      return code;
   endfunction

endpackage

/* rtl/core/cigar_string_parser.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cigar_string_parser
// Parses a NUL-terminated CIGAR string one byte per beat into operations
// with run length and running total; optional malformed-string checking.
// ---------------------------------------------------------------------------
//  channel   ports    direction  payload
//  request   req_*    in         char_in (8 bits)
//  response  rsp_*    out        op_code, op_char, run_length, total_length,
//                                is_end, malformed, unknown_op
//  csr       csr_*    in         check_mode (write only)
//
//  one byte per cycle unless a byte that makes a result waits on a stalled response;
//  a result goes from the input register through the parse logic into the result register
//  the x10 add and the running-total add set the path between the registers
//  reset clears the string state and the pipeline and sets check_mode to 1
//  a stalled response holds; digits and discarded bytes keep flowing behind
//  it, a byte that makes a result waits in the input register (req_stall)
// ---------------------------------------------------------------------------
module cigar_string_parser #(
   parameter int unsigned LEN_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_char_in,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [3:0]  rsp_op_code,
   output logic [7:0]  rsp_op_char,
   output logic [31:0] rsp_run_length,
   output logic [31:0] rsp_total_length,
   output logic        rsp_is_end,
   output logic        rsp_malformed,
   output logic        rsp_unknown_op,
   input  logic        csr_wr_en,
   input  logic        csr_wr_data
);

   localparam int unsigned WIDE_BITS = LEN_BITS + 4;
   localparam int unsigned OUT_BITS  = csp_pkg::OUT_LEN_BITS;

   // input stage
   logic                s1_valid_ff, s1_valid_in;
   logic [7:0]          s1_char_ff;
   logic                s1_load, s1_adv;

   // configuration and string state
   logic                check_mode_ff;
   logic [LEN_BITS-1:0] pend_ff, pend_in;
   logic                digits_ff, digits_in;
   logic [LEN_BITS-1:0] total_ff, total_in;
   logic                discard_ff, discard_in;

   // result register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [3:0]          rsp_op_code_ff, rsp_op_code_in;
   logic [7:0]          rsp_op_char_ff, rsp_op_char_in;
   logic [31:0]         rsp_run_ff, rsp_run_in;
   logic [31:0]         rsp_total_ff, rsp_total_in;
   logic                rsp_end_ff, rsp_end_in;
   logic                rsp_bad_ff, rsp_bad_in;
   logic                rsp_unk_ff, rsp_unk_in;

   // parse logic
   logic                    out_free;
   logic                    emit;
   logic                    is_digit, is_nul;
   csp_pkg::op_code_type    code;
   logic [3:0]              digit_value;
   logic [WIDE_BITS-1:0]    pend_wide, times_ten;
   logic [LEN_BITS-1:0]     pend_next_digit;
   logic [LEN_BITS-1:0]     total_plus;
   logic [LEN_BITS-1:0]     res_run, res_total;
   logic [3:0]              res_code;
   logic [7:0]              res_char;
   logic                    res_end, res_bad, res_unk;
   logic [LEN_BITS+OUT_BITS-1:0] run_ext, total_ext;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign s1_adv    = !emit || out_free;
   assign req_stall = s1_valid_ff && !s1_adv;
   assign s1_load   = req_valid && !req_stall;

   assign is_digit    = (s1_char_ff >= csp_pkg::CHAR_ZERO) &&
                        (s1_char_ff <= csp_pkg::CHAR_NINE);
   assign is_nul      = (s1_char_ff == csp_pkg::CHAR_NUL);
   assign code        = csp_pkg::op_lookup(s1_char_ff);
   assign digit_value = 4'(s1_char_ff - csp_pkg::CHAR_ZERO);

   // pending * 10 + digit, saturating at all ones
   assign pend_wide = WIDE_BITS'(pend_ff);
   assign times_ten = pend_wide * WIDE_BITS'(csp_pkg::DECIMAL_BASE) + WIDE_BITS'(digit_value);
   assign pend_next_digit = (times_ten[WIDE_BITS-1:LEN_BITS] != '0) ? '1
                                                                    : times_ten[LEN_BITS-1:0];

   assign total_plus = total_ff + pend_ff;

   always_comb begin
      pend_in    = pend_ff;
      digits_in  = digits_ff;
      total_in   = total_ff;
      discard_in = discard_ff;
      emit       = 1'b0;
      res_code   = csp_pkg::OP_END;
      res_char   = csp_pkg::CHAR_NUL;
      res_run    = '0;
      res_total  = total_ff;
      res_end    = 1'b0;
      res_bad    = 1'b0;
      res_unk    = 1'b0;
      priority if (discard_ff) begin
         if (is_nul) begin
            pend_in    = '0;
            digits_in  = 1'b0;
            total_in   = '0;
            discard_in = 1'b0;
         end
      end else if (is_digit) begin
         pend_in   = pend_next_digit;
         digits_in = 1'b1;
      end else if (is_nul) begin
         emit      = 1'b1;
         res_run   = pend_ff;
         res_end   = 1'b1;
         // trailing digits are flagged, not added, when checking
         res_bad   = digits_ff && check_mode_ff;
         res_total = res_bad ? total_ff : total_plus;
         pend_in   = '0;
         digits_in = 1'b0;
         total_in  = '0;
      end else begin
         emit     = 1'b1;
         res_code = code;
         res_char = s1_char_ff;
         res_unk  = check_mode_ff && (code == csp_pkg::OP_UNKNOWN);
         if (check_mode_ff && !digits_ff) begin
            // letter with no length closes the string, skip up to the nul
            res_end    = 1'b1;
            res_bad    = 1'b1;
            pend_in    = '0;
            digits_in  = 1'b0;
            total_in   = '0;
            discard_in = 1'b1;
         end else begin
            res_run   = pend_ff;
            res_total = total_plus;
            total_in  = total_plus;
            pend_in   = '0;
            digits_in = 1'b0;
         end
      end
   end

   assign run_ext   = {{OUT_BITS{1'b0}}, res_run};
   assign total_ext = {{OUT_BITS{1'b0}}, res_total};

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (s1_load) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_op_code_in = rsp_op_code_ff;
      rsp_op_char_in = rsp_op_char_ff;
      rsp_run_in     = rsp_run_ff;
      rsp_total_in   = rsp_total_ff;
      rsp_end_in     = rsp_end_ff;
      rsp_bad_in     = rsp_bad_ff;
      rsp_unk_in     = rsp_unk_ff;
      if (s1_valid_ff && emit && out_free) begin
         rsp_valid_in   = 1'b1;
         rsp_op_code_in = res_code;
         rsp_op_char_in = res_char;
         rsp_run_in     = run_ext[OUT_BITS-1:0];
         rsp_total_in   = total_ext[OUT_BITS-1:0];
         rsp_end_in     = res_end;
         rsp_bad_in     = res_bad;
         rsp_unk_in     = res_unk;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         check_mode_ff <= 1'b1;
         pend_ff       <= '0;
         digits_ff     <= 1'b0;
         total_ff      <= '0;
         discard_ff    <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            check_mode_ff <= csr_wr_data;
         end
         if (s1_valid_ff && s1_adv) begin
            pend_ff    <= pend_in;
            digits_ff  <= digits_in;
            total_ff   <= total_in;
            discard_ff <= discard_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_char_ff <= req_char_in;
      end
      rsp_op_code_ff <= rsp_op_code_in;
      rsp_op_char_ff <= rsp_op_char_in;
      rsp_run_ff     <= rsp_run_in;
      rsp_total_ff   <= rsp_total_in;
      rsp_end_ff     <= rsp_end_in;
      rsp_bad_ff     <= rsp_bad_in;
      rsp_unk_ff     <= rsp_unk_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_op_code      = rsp_op_code_ff;
   assign rsp_op_char      = rsp_op_char_ff;
   assign rsp_run_length   = rsp_run_ff;
   assign rsp_total_length = rsp_total_ff;
   assign rsp_is_end       = rsp_end_ff;
   assign rsp_malformed    = rsp_bad_ff;
   assign rsp_unknown_op   = rsp_unk_ff;

endmodule

/* rtl/core/csp_checker.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// csp_checker
// Port-level assertions for the cigar string parser, bound to the top level.
// ---------------------------------------------------------------------------
`include "cigar_string_parser_assert.svh"

module csp_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [3:0]  rsp_op_code,
   input logic [7:0]  rsp_op_char,
   input logic [31:0] rsp_run_length,
   input logic [31:0] rsp_total_length,
   input logic        rsp_is_end,
   input logic        rsp_malformed,
   input logic        rsp_unknown_op
);

   logic [78:0] rsp_beat;
   logic        rsp_held;
   logic        unk_code;
   logic        end_code;

   assign rsp_beat = {rsp_op_code, rsp_op_char, rsp_run_length, rsp_total_length,
                      rsp_is_end, rsp_malformed, rsp_unknown_op};
   assign rsp_held = rsp_valid && rsp_stall;
   assign unk_code = (rsp_op_code == csp_pkg::OP_UNKNOWN);
   assign end_code = (rsp_op_code == csp_pkg::OP_END);

   // a stalled response beat holds
   `CSP_ASSERT(a_rsp_hold, rsp_held |=> rsp_valid && $stable(rsp_beat), "stalled beat changed")

   // a malformed string always closes on that beat
   `CSP_ASSERT(a_bad_closes, rsp_valid && rsp_malformed |-> rsp_is_end, "malformed without end")

   `CSP_ASSERT(a_unk_code, rsp_valid && rsp_unknown_op |-> unk_code, "unknown flag, known op")

   // end code only on a closing beat
   `CSP_ASSERT(a_end_code, rsp_valid && end_code |-> rsp_is_end, "end code without end flag")

   `CSP_ASSERT_ALWAYS(a_reset_idle, reset |=> !rsp_valid, "response valid right after reset")

endmodule

bind cigar_string_parser csp_checker u_csp_checker (.*);

/* tb/tb_cigar_string_parser.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_cigar_string_parser
// Streams CIGAR strings into the parser one byte per beat and checks every
// result beat against a cycle-free model of the parser kept in the bench.
// Directed strings cover all operations, saturation, total wrap and the
// malformed cases; random strings follow, mostly well formed, under both
// checking modes and several idle and stall patterns on either side.
// ---------------------------------------------------------------------------
module tb_cigar_string_parser;

   localparam logic [63:0] RUN_MAX      = 64'hFFFF_FFFF;
   localparam int          DRAIN_CYCLES = 8;
   localparam int          PHASE_CHARS  = 230;
   localparam int          PRINT_LIMIT  = 50;

   typedef enum int {
      IDLE_NONE,
      IDLE_SENDER,
      IDLE_RECEIVER,
      IDLE_BOTH
   } idle_mode_type;

   typedef struct {
      csp_pkg::op_code_type code;
      logic [7:0]           ch;
      logic [31:0]          run_len;
      logic [31:0]          total_len;
      logic                 last;
      logic                 bad;
      logic                 unk;
   } op_result_type;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_valid   = 1'b0;
   logic        req_stall;
   logic [7:0]  req_char_in = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall   = 1'b0;
   logic [3:0]  rsp_op_code;
   logic [7:0]  rsp_op_char;
   logic [31:0] rsp_run_length;
   logic [31:0] rsp_total_length;
   logic        rsp_is_end;
   logic        rsp_malformed;
   logic        rsp_unknown_op;
   logic        csr_wr_en   = 1'b0;
   logic        csr_wr_data = 1'b0;

   logic [7:0]     char_backlog[$];
   op_result_type  expected_ops[$];
   idle_mode_type  idle_mode = IDLE_NONE;
   int             error_count = 0;
   int             queued_chars;
   bit             req_accepted = 1'b0;

   // parser state as the bench sees it
   logic        check_on;
   logic [63:0] pending_len;
   logic        digits_seen;
   logic [63:0] total;
   logic        discarding;

   cigar_string_parser dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_char_in      (req_char_in),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_op_code      (rsp_op_code),
      .rsp_op_char      (rsp_op_char),
      .rsp_run_length   (rsp_run_length),
      .rsp_total_length (rsp_total_length),
      .rsp_is_end       (rsp_is_end),
      .rsp_malformed    (rsp_malformed),
      .rsp_unknown_op   (rsp_unknown_op),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic void clear_string();
      pending_len = '0;
      digits_seen = 1'b0;
      total       = '0;
      discarding  = 1'b0;
   endfunction

   function automatic csp_pkg::op_code_type letter_code(input logic [7:0] c);
      unique case (c)
         csp_pkg::CHAR_M:  return csp_pkg::OP_M;
         csp_pkg::CHAR_EQ: return csp_pkg::OP_EQ;
         csp_pkg::CHAR_X:  return csp_pkg::OP_X;
         csp_pkg::CHAR_I:  return csp_pkg::OP_I;
         csp_pkg::CHAR_D:  return csp_pkg::OP_D;
         csp_pkg::CHAR_S:  return csp_pkg::OP_S;
         csp_pkg::CHAR_N:  return csp_pkg::OP_N;
         csp_pkg::CHAR_H:  return csp_pkg::OP_H;
         csp_pkg::CHAR_P:  return csp_pkg::OP_P;
         default:          return csp_pkg::OP_UNKNOWN;
      endcase
   endfunction

   // advances the parser state by one byte; returns 1 when a result is due
   function automatic bit parse_cigar_char(input logic [7:0] c, output op_result_type r);
      logic [63:0] digit;
      r.code      = csp_pkg::OP_END;
      r.ch        = c;
      r.run_len   = '0;
      r.total_len = '0;
      r.last      = 1'b0;
      r.bad       = 1'b0;
      r.unk       = 1'b0;
      if (discarding) begin
         if (c == csp_pkg::CHAR_NUL)
            clear_string();
         return 1'b0;
      end
      if (c >= csp_pkg::CHAR_ZERO && c <= csp_pkg::CHAR_NINE) begin
         digit = 64'(c) - 64'(csp_pkg::CHAR_ZERO);
         if (pending_len > (RUN_MAX - digit) / 64'd10)
            pending_len = RUN_MAX;
         else
            pending_len = pending_len * 64'd10 + digit;
         digits_seen = 1'b1;
         return 1'b0;
      end
      if (c == csp_pkg::CHAR_NUL) begin
         r.run_len = pending_len[31:0];
         r.last    = 1'b1;
         if (digits_seen && check_on) begin
            // trailing digits are reported but not added
            r.total_len = total[31:0];
            r.bad       = 1'b1;
         end else begin
            r.total_len = 32'((total + pending_len) & RUN_MAX);
         end
         clear_string();
         return 1'b1;
      end
      r.code = letter_code(c);
      r.unk  = check_on && (r.code == csp_pkg::OP_UNKNOWN);
      if (check_on && !digits_seen) begin
         // letter with no length closes the string; skip to the nul
         r.total_len = total[31:0];
         r.last      = 1'b1;
         r.bad       = 1'b1;
         clear_string();
         discarding = 1'b1;
         return 1'b1;
      end
      total       = (total + pending_len) & RUN_MAX;
      r.run_len   = pending_len[31:0];
      r.total_len = total[31:0];
      pending_len = '0;
      digits_seen = 1'b0;
      return 1'b1;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      if (error_count < PRINT_LIMIT)
         $display("%0t mismatch %s: got 0x%0h expected 0x%0h", $realtime, what, got, want);
      error_count++;
   endtask

   function automatic bit roll(input int percent);
      return $urandom_range(99) < percent;
   endfunction

   // monitor and predictor share one clocked block so pops follow pushes
   always @(posedge clock) begin : track
      op_result_type want;
      op_result_type got_op;
      if (reset) begin
         check_on = 1'b1;
         clear_string();
         req_accepted = 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_ops.size() == 0) begin
               report_mismatch("result beat with none expected", rsp_op_code, 0);
            end else begin
               want = expected_ops.pop_front();
               if (rsp_op_code != want.code)
                  report_mismatch("op_code", rsp_op_code, want.code);
               if (rsp_op_char != want.ch)
                  report_mismatch("op_char", rsp_op_char, want.ch);
               if (rsp_run_length != want.run_len)
                  report_mismatch("run_length", rsp_run_length, want.run_len);
               if (rsp_total_length != want.total_len)
                  report_mismatch("total_length", rsp_total_length, want.total_len);
               if (rsp_is_end != want.last)
                  report_mismatch("is_end", rsp_is_end, want.last);
               if (rsp_malformed != want.bad)
                  report_mismatch("malformed", rsp_malformed, want.bad);
               if (rsp_unknown_op != want.unk)
                  report_mismatch("unknown_op", rsp_unknown_op, want.unk);
            end
         end
         if (csr_wr_en)
            check_on = csr_wr_data;
         req_accepted = req_valid && !req_stall;
         if (req_accepted && parse_cigar_char(req_char_in, got_op))
            expected_ops = {expected_ops, got_op};
      end
   end

   always @(negedge clock) begin : drive_req
      logic       next_valid;
      logic [7:0] next_char;
      bit         pause;
      next_valid = req_valid;
      next_char  = req_char_in;
      pause = (idle_mode == IDLE_SENDER && roll(64)) || (idle_mode == IDLE_BOTH && roll(7));
      if (reset) begin
         next_valid = 1'b0;
      end else if (!req_valid || req_accepted) begin
         next_valid = 1'b0;
         if (char_backlog.size() != 0 && !pause) begin
            next_char  = char_backlog.pop_front();
            next_valid = 1'b1;
         end
      end
      req_valid   <= next_valid;
      req_char_in <= next_char;
   end

   always @(negedge clock) begin
      rsp_stall <= !reset &&
                   ((idle_mode == IDLE_RECEIVER && roll(64)) || (idle_mode == IDLE_BOTH && roll(7)));
   end

   task automatic push_char(input logic [7:0] c);
      char_backlog = {char_backlog, c};
      queued_chars++;
   endtask

   task automatic push_text(input string s);
      for (int k = 0; k < s.len(); k++)
         push_char(s[k]);
      push_char(csp_pkg::CHAR_NUL);
   endtask

   function automatic logic [7:0] known_letter(input int idx);
      unique case (idx)
         0:       return csp_pkg::CHAR_M;
         1:       return csp_pkg::CHAR_EQ;
         2:       return csp_pkg::CHAR_X;
         3:       return csp_pkg::CHAR_I;
         4:       return csp_pkg::CHAR_D;
         5:       return csp_pkg::CHAR_S;
         6:       return csp_pkg::CHAR_N;
         7:       return csp_pkg::CHAR_H;
         default: return csp_pkg::CHAR_P;
      endcase
   endfunction

   function automatic logic [7:0] odd_letter();
      logic [7:0] c;
      do
         c = 8'($urandom_range(1, 255));
      while (c >= csp_pkg::CHAR_ZERO && c <= csp_pkg::CHAR_NINE);
      return c;
   endfunction

   task automatic push_digits(input int count);
      for (int k = 0; k < count; k++)
         push_char(csp_pkg::CHAR_ZERO + 8'($urandom_range(9)));
   endtask

   task automatic push_random_string();
      int n_ops;
      int n_dig;
      if (roll(85)) begin
         n_ops = $urandom_range(1, 6);
         for (int k = 0; k < n_ops; k++) begin
            if (roll(3))
               n_dig = 0;
            else if (roll(5))
               n_dig = $urandom_range(10, 12);
            else
               n_dig = $urandom_range(1, 3);
            push_digits(n_dig);
            push_char(roll(90) ? known_letter($urandom_range(8)) : odd_letter());
         end
         if (roll(10))
            push_digits($urandom_range(1, 4));
      end else begin
         // noise: any byte value, a stray nul included
         n_ops = $urandom_range(1, 10);
         for (int k = 0; k < n_ops; k++)
            push_char(8'($urandom_range(255)));
      end
      push_char(csp_pkg::CHAR_NUL);
   endtask

   task automatic wait_idle();
      while (char_backlog.size() != 0 || req_valid || expected_ops.size() != 0)
         @(negedge clock);
      // digits and skipped bytes may still be in the pipe
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_check_mode(input logic value);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   initial begin
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      // checking on after reset: every operation, a bare letter, trailing digits
      push_text("1M2=3X4I5D6S7N8H9P");
      push_text("Q");
      push_text("7");
      wait_idle();

      // checking off: saturation, total wrap, unknown and bare letters
      write_check_mode(1'b0);
      push_text("4294967296M4294967295Z+");
      wait_idle();

      for (int p = 0; p < 8; p++) begin
         write_check_mode(p[2]);
         idle_mode    = idle_mode_type'(p % 4);
         queued_chars = 0;
         while (queued_chars < PHASE_CHARS)
            push_random_string();
         wait_idle();
      end

      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/csp_pkg.sv
rtl/core/cigar_string_parser.sv
rtl/core/csp_checker.sv
tb/tb_cigar_string_parser.sv
